// ----- design/bale_pkg.sv -----
// ---------------------------------------------------------------------------
// bale_pkg - shared types and constants for the bounded array list engine
// Request/result payload structs, action codes and register map.
// ---------------------------------------------------------------------------
package bale_pkg;

    // Storage depth default
    localparam int DEPTH_DEFAULT = 256;

    // Action codes carried in the request
    localparam logic [2:0] ACT_APPEND      = 3'd0;
    localparam logic [2:0] ACT_READ        = 3'd1;
    localparam logic [2:0] ACT_REMOVE_SWAP = 3'd2;
    localparam logic [2:0] ACT_REMOVE_KEEP = 3'd3;
    localparam logic [2:0] ACT_REMOVE_ALL  = 3'd4;

    // Register map (word index taken from paddr[2])
    localparam int         PADDR_W      = 3;
    localparam logic       REG_CAPACITY = 1'b0;
    localparam logic [8:0] CAP_RESET    = 9'd256;

    // One request
    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] value;
        logic [7:0]         index;
    } t_request;

    // One result
    typedef struct packed {
        logic               ok;
        logic signed [31:0] read_data;
        logic [8:0]         removed_count;
        logic [8:0]         fill_level;
    } t_result;

endpackage

// ----- design/bale_cfg.sv -----
// ---------------------------------------------------------------------------
// bale_cfg - APB register slice
// Holds the capacity register; writes complete in the access phase.
// ---------------------------------------------------------------------------
module bale_cfg
    import bale_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [8:0]         o_capacity
);

    logic [8:0] r_capacity;
    logic       wr_en;

    // Write strobe, low address bits are byte offset
    assign wr_en = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (wr_en) begin
            r_capacity <= pwdata[8:0];
        end
    end

    // Read-back
    always_comb begin
        if (paddr[2] == REG_CAPACITY) begin
            prdata = {23'd0, r_capacity};
        end else begin
            prdata = 32'd0;
        end
    end

    assign pready     = 1'b1;
    assign o_capacity = r_capacity;

endmodule

// ----- design/bale_ctrl.sv -----
// ---------------------------------------------------------------------------
// bale_ctrl - list storage and sequencer
// One comparator and one read/one write memory port, stepped over the stored
// entries for the remove actions; append finishes at once, read via S_RD_WAIT.
// ---------------------------------------------------------------------------
module bale_ctrl
    import bale_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_request   i_req,
    input  logic [8:0] i_capacity,
    output logic       o_busy,
    output logic       o_res_valid,
    output t_result    o_res
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_WAIT,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SWAP_WR
    } t_state;

    // Storage
    logic [31:0] mem [DEPTH];
    logic [31:0] r_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [31:0]   mem_wd;
    logic [AW-1:0] mem_ra;

    // Sequencer registers
    t_state      r_state, n_state;
    logic [CW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_removed, n_removed;
    logic [31:0]   r_value, n_value;
    logic [2:0]    r_mode, n_mode;
    logic          r_res_valid, n_res_valid;
    t_result       r_res, n_res;

    // Shared compare unit and scan arithmetic
    logic          hit;
    logic          drop;
    logic          at_last;
    logic [CW-1:0] last_pos;
    logic [CW-1:0] scan_removed;
    logic [CW-1:0] scan_j;
    logic          can_append;
    logic          read_ok;

    assign hit          = (r_rdata == r_value);
    assign last_pos     = r_fill - CW'(1);
    assign at_last      = (r_i == last_pos);
    assign drop         = hit && ((r_mode == ACT_REMOVE_ALL) || (r_removed == '0));
    assign scan_removed = r_removed + CW'(drop);
    assign scan_j       = r_j + CW'(!drop);
    assign can_append   = (32'(r_fill) < 32'(i_capacity)) && (32'(r_fill) < DEPTH);
    assign read_ok      = (32'(i_req.index) < 32'(r_fill));

    // Memory port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[mem_ra];
    end

    // Next-state logic
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_i         = r_i;
        n_j         = r_j;
        n_removed   = r_removed;
        n_value     = r_value;
        n_mode      = r_mode;
        n_res_valid = 1'b0;
        n_res       = r_res;
        mem_we      = 1'b0;
        mem_wa      = r_j[AW-1:0];
        mem_wd      = r_rdata;
        mem_ra      = r_i[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_value   = i_req.value;
                    n_mode    = i_req.action;
                    n_i       = '0;
                    n_j       = '0;
                    n_removed = '0;
                    n_res.ok            = 1'b0;
                    n_res.read_data     = '0;
                    n_res.removed_count = '0;
                    n_res.fill_level    = 9'(r_fill);
                    case (i_req.action)
                        ACT_APPEND: begin
                            n_res_valid = 1'b1;
                            if (can_append) begin
                                mem_we           = 1'b1;
                                mem_wa           = r_fill[AW-1:0];
                                mem_wd           = i_req.value;
                                n_fill           = r_fill + CW'(1);
                                n_res.ok         = 1'b1;
                                n_res.fill_level = 9'(r_fill + CW'(1));
                            end
                        end
                        ACT_READ: begin
                            mem_ra = AW'(i_req.index);
                            if (read_ok) begin
                                n_state = S_RD_WAIT;
                            end else begin
                                n_res_valid = 1'b1;
                            end
                        end
                        ACT_REMOVE_SWAP, ACT_REMOVE_KEEP, ACT_REMOVE_ALL: begin
                            if (r_fill == '0) begin
                                n_res_valid = 1'b1;
                            end else begin
                                n_state = S_SCAN_RD;
                            end
                        end
                        default: begin
                            n_res_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_RD_WAIT: begin
                n_res_valid     = 1'b1;
                n_res.ok        = 1'b1;
                n_res.read_data = r_rdata;
                n_state         = S_IDLE;
            end
            S_SCAN_RD: begin
                // address r_i presented, data lands next cycle
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (r_mode == ACT_REMOVE_SWAP) begin
                    mem_ra = last_pos[AW-1:0];
                    if (hit) begin
                        n_state = S_SWAP_WR;
                    end else if (at_last) begin
                        n_res_valid = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        n_i     = r_i + CW'(1);
                        n_state = S_SCAN_RD;
                    end
                end else begin
                    // compaction: kept entries move down to the write pointer
                    mem_we    = !drop;
                    mem_wa    = r_j[AW-1:0];
                    mem_wd    = r_rdata;
                    n_j       = scan_j;
                    n_removed = scan_removed;
                    if (at_last) begin
                        n_fill              = scan_j;
                        n_res_valid         = 1'b1;
                        n_res.ok            = (scan_removed != '0);
                        n_res.removed_count = 9'(scan_removed);
                        n_res.fill_level    = 9'(scan_j);
                        n_state             = S_IDLE;
                    end else begin
                        n_i     = r_i + CW'(1);
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_SWAP_WR: begin
                // last entry fills the hole left by the match
                mem_we              = 1'b1;
                mem_wa              = r_i[AW-1:0];
                mem_wd              = r_rdata;
                n_fill              = last_pos;
                n_res_valid         = 1'b1;
                n_res.ok            = 1'b1;
                n_res.removed_count = 9'd1;
                n_res.fill_level    = 9'(last_pos);
                n_state             = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_res_valid <= n_res_valid;
        end
        r_i       <= n_i;
        r_j       <= n_j;
        r_removed <= n_removed;
        r_value   <= n_value;
        r_mode    <= n_mode;
        r_res     <= n_res;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

// ----- design/bounded_array_list_engine_top.sv -----
// ---------------------------------------------------------------------------
// bounded_array_list_engine_top - bounded list of signed words
// Append, read by position and three kinds of remove-by-value.
//
//   channel   signals                             handshake
//   request   start, busy, i_request              taken when start && !busy
//   result    o_result_valid, o_result            one cycle, no back-pressure
//   config    psel/penable/pwrite/paddr/pwdata    APB, pready tied high
//
// Append, read miss, unknown action and remove on an empty list: result in
// the next cycle. Successful read: the data is registered in S_RD_WAIT first.
// Remove actions scan with one memory read port and one comparator, visiting
// each entry in S_SCAN_RD then S_SCAN_CHK: keep-order, remove-all and a
// swap-last miss visit every entry; a swap-last hit stops at the match.
// Synchronous reset empties the list; no clearing pass is needed.
// The result cannot be stalled; busy is low in the cycle it is shown.
// ---------------------------------------------------------------------------
module bounded_array_list_engine_top
    import bale_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_request           i_request,
    output logic               o_result_valid,
    output t_result            o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [8:0] capacity;

    // Register slice
    bale_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_capacity (capacity)
    );

    // Storage and sequencer
    bale_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (i_request),
        .i_capacity  (capacity),
        .o_busy      (busy),
        .o_res_valid (o_result_valid),
        .o_res       (o_result)
    );

endmodule

// ----- design/bale_checker.sv -----
// ---------------------------------------------------------------------------
// bale_checker - port-level checks for the list engine
// Request/result sequencing and result field consistency.
// ---------------------------------------------------------------------------
module bale_checker
    import bale_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input logic    o_result_valid,
    input t_result o_result
);

    // An accepted request either keeps the engine busy or answers at once
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_result_valid))
        else $error("accepted request neither busy nor answered");

    // A result is shown only once the sequencer has gone idle
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result shown while busy");

    // No result without a request in flight the cycle before
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy || start))
        else $error("result without request");

    // A failed action reports nothing read and nothing removed
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.ok) |->
            (o_result.removed_count == 9'd0 && o_result.read_data == 32'sd0))
        else $error("failed action carries data");

endmodule

bind bounded_array_list_engine_top bale_checker u_bale_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);
